@@ hw/rtl/brf_pkg.sv @@
package brf_pkg;

  localparam int DEPTH       = 256;
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int FILL_W      = IDX_W + 1;
  localparam int BLOCK_BYTES = 8;
  localparam int MAX_COUNT   = 64;
  localparam int CNT_W       = 7;

  // Input kind codes.
  localparam logic [2:0] KIND_CLEAR      = 3'd0;
  localparam logic [2:0] KIND_PUSH_BYTE  = 3'd1;
  localparam logic [2:0] KIND_POP_BYTE   = 3'd2;
  localparam logic [2:0] KIND_PUSH_BLOCK = 3'd3;
  localparam logic [2:0] KIND_POP_BLOCK  = 3'd4;
  localparam logic [2:0] KIND_POP_DELIM  = 3'd5;

  // Result status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_SHORT    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_TOOBIG   = 2'd3;

  typedef enum logic [2:0] {
    OP_CLEAR, OP_PUSH_BYTE, OP_POP_BYTE, OP_PUSH_BLOCK, OP_POP_BLOCK, OP_POP_DELIM, OP_BAD
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE, S_PUSH, S_SCAN_RD, S_SCAN_CHK, S_POP_RD, S_POP_EMIT, S_DROP, S_RESULT
  } state_t;

  typedef struct packed {
    op_t              op;
    logic [63:0]      wdata;
    logic [CNT_W-1:0] count;
    logic [7:0]       delim;
    logic             too_big;
  } cmd_t;

  typedef struct packed {
    logic [7:0]        data_byte;
    logic              data_valid;
    logic              last;
    logic [1:0]        status;
    logic [CNT_W-1:0]  before_cnt;
    logic [FILL_W-1:0] fill;
  } res_t;

  // Ring index step: wraps at the capacity in use.
  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] idx,
                                          input logic [FILL_W-1:0] cap);
    logic [FILL_W-1:0] nx;
    nx = {1'b0, idx} + FILL_W'(1);
    return (nx >= cap) ? '0 : nx[IDX_W-1:0];
  endfunction

endpackage

@@ hw/rtl/brf_front.sv @@
module brf_front import brf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_kind,
  input  logic [63:0] in_wdata,
  input  logic [CNT_W-1:0] in_count,
  input  logic [7:0]  in_delim,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  cmd_t dec;
  logic vld;

  always_comb begin
    dec.wdata = in_wdata;
    dec.count = in_count;
    dec.delim = in_delim;
    unique case (in_kind)
      KIND_CLEAR:      dec.op = OP_CLEAR;
      KIND_PUSH_BYTE:  dec.op = OP_PUSH_BYTE;
      KIND_POP_BYTE:   dec.op = OP_POP_BYTE;
      KIND_PUSH_BLOCK: dec.op = OP_PUSH_BLOCK;
      KIND_POP_BLOCK:  dec.op = OP_POP_BLOCK;
      KIND_POP_DELIM:  dec.op = OP_POP_DELIM;
      default:         dec.op = OP_BAD;
    endcase
    dec.too_big = ((dec.op == OP_PUSH_BLOCK) && (in_count > CNT_W'(BLOCK_BYTES))) ||
                  (((dec.op == OP_POP_BLOCK) || (dec.op == OP_POP_DELIM)) &&
                   (in_count > CNT_W'(MAX_COUNT)));
  end

  assign in_ready  = !vld || cmd_ready;
  assign cmd_valid = vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cmd <= dec;
    end
  end

endmodule

@@ hw/rtl/brf_cmd_q.sv @@
module brf_cmd_q import brf_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  cmd_t in_cmd,
  output logic out_valid,
  input  logic out_ready,
  output cmd_t out_cmd
);

  cmd_t       slots [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;

  assign in_ready  = (cnt != 2'd2);
  assign out_valid = (cnt != 2'd0);
  assign out_cmd   = slots[rp];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= !wp;
      if (pop) rp <= !rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wp] <= in_cmd;
  end

endmodule

@@ hw/rtl/brf_back.sv @@
module brf_back import brf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_clear,
  input  logic [FILL_W-1:0] cap,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;

  state_t state, state_next;
  cmd_t   cur, cur_next;
  logic [IDX_W-1:0]  rd_idx, rd_idx_next, wr_idx, wr_idx_next, ptr, ptr_next;
  logic [FILL_W-1:0] held, held_next, fin, fin_next;
  logic [CNT_W-1:0]  i, i_next, n, n_next, bef, bef_next, lim, lim_next;
  logic [1:0]        st, st_next;
  logic              drop, drop_next;
  logic              o_valid, o_valid_next;
  res_t              o_res, o_res_next;

  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;
  logic [7:0]        wbyte;
  logic              out_free;
  logic [FILL_W-1:0] cnt9, space;

  assign res_valid = o_valid;
  assign res       = o_res;
  assign out_free  = !o_valid || res_ready;
  assign cnt9      = {{(FILL_W-CNT_W){1'b0}}, cmd.count};
  assign space     = cap - held;

  always_comb begin
    state_next  = state;
    cur_next    = cur;
    rd_idx_next = rd_idx;
    wr_idx_next = wr_idx;
    ptr_next    = ptr;
    held_next   = held;
    fin_next    = fin;
    i_next      = i;
    n_next      = n;
    bef_next    = bef;
    lim_next    = lim;
    st_next     = st;
    drop_next   = drop;
    o_valid_next = o_valid && !res_ready;
    o_res_next  = o_res;
    cmd_ready   = 1'b0;
    we          = 1'b0;
    re          = 1'b0;
    waddr       = wr_idx;
    raddr       = rd_idx;
    wbyte       = cmd.wdata[7:0];

    unique case (state)
      S_IDLE: begin
        cmd_ready = !cfg_clear;
        if (cmd_valid && !cfg_clear) begin
          cur_next  = cmd;
          st_next   = ST_OK;
          fin_next  = held;
          i_next    = '0;
          bef_next  = '0;
          drop_next = 1'b0;
          state_next = S_RESULT;
          if (cmd.too_big) begin
            st_next = ST_TOOBIG;
          end else begin
            unique case (cmd.op)
              OP_CLEAR: begin
                rd_idx_next = '0;
                wr_idx_next = '0;
                held_next   = '0;
                fin_next    = '0;
              end
              OP_PUSH_BYTE: begin
                if (held >= cap) begin
                  st_next = ST_SHORT;
                end else begin
                  we          = 1'b1;
                  wr_idx_next = adv(wr_idx, cap);
                  held_next   = held + FILL_W'(1);
                  fin_next    = held + FILL_W'(1);
                end
              end
              OP_POP_BYTE, OP_POP_BLOCK: begin
                if (cmd.op == OP_POP_BYTE && held == '0) begin
                  st_next = ST_SHORT;
                end else if (cmd.op == OP_POP_BLOCK && held < cnt9) begin
                  st_next = ST_SHORT;
                end else if (cmd.op == OP_POP_BLOCK && cmd.count == '0) begin
                  st_next = ST_OK;
                end else begin
                  n_next     = (cmd.op == OP_POP_BYTE) ? CNT_W'(1) : cmd.count;
                  held_next  = held - ((cmd.op == OP_POP_BYTE) ? FILL_W'(1) : cnt9);
                  fin_next   = held - ((cmd.op == OP_POP_BYTE) ? FILL_W'(1) : cnt9);
                  state_next = S_POP_RD;
                end
              end
              OP_PUSH_BLOCK: begin
                if (space < cnt9) begin
                  st_next = ST_SHORT;
                end else begin
                  held_next  = held + cnt9;
                  fin_next   = held + cnt9;
                  state_next = S_PUSH;
                end
              end
              OP_POP_DELIM: begin
                lim_next = (cnt9 > held) ? held[CNT_W-1:0] : cmd.count;
                ptr_next = rd_idx;
                if (cmd.count == '0 || held == '0) begin
                  st_next = ST_NOTFOUND;
                end else begin
                  state_next = S_SCAN_RD;
                end
              end
              default: st_next = ST_SHORT;
            endcase
          end
        end
      end
      S_PUSH: begin
        if (i == cur.count) begin
          state_next = S_RESULT;
        end else begin
          we          = 1'b1;
          wbyte       = cur.wdata[{i[2:0], 3'b000} +: 8];
          wr_idx_next = adv(wr_idx, cap);
          i_next      = i + CNT_W'(1);
        end
      end
      S_SCAN_RD: begin
        re         = 1'b1;
        raddr      = ptr;
        state_next = S_SCAN_CHK;
      end
      S_SCAN_CHK: begin
        if (rdata == cur.delim) begin
          if (i == '0) begin
            rd_idx_next = adv(rd_idx, cap);
            held_next   = held - FILL_W'(1);
            fin_next    = held - FILL_W'(1);
            state_next  = S_RESULT;
          end else begin
            n_next     = i;
            bef_next   = i;
            drop_next  = 1'b1;
            held_next  = held - {{(FILL_W-CNT_W){1'b0}}, i} - FILL_W'(1);
            fin_next   = held - {{(FILL_W-CNT_W){1'b0}}, i} - FILL_W'(1);
            i_next     = '0;
            state_next = S_POP_RD;
          end
        end else if (i + CNT_W'(1) == lim) begin
          st_next    = ST_NOTFOUND;
          state_next = S_RESULT;
        end else begin
          i_next     = i + CNT_W'(1);
          ptr_next   = adv(ptr, cap);
          state_next = S_SCAN_RD;
        end
      end
      S_POP_RD: begin
        re         = 1'b1;
        raddr      = rd_idx;
        state_next = S_POP_EMIT;
      end
      S_POP_EMIT: begin
        if (out_free) begin
          o_valid_next          = 1'b1;
          o_res_next.data_byte  = rdata;
          o_res_next.data_valid = 1'b1;
          o_res_next.last       = (i + CNT_W'(1) == n);
          o_res_next.status     = ST_OK;
          o_res_next.before_cnt = bef;
          o_res_next.fill       = fin;
          rd_idx_next           = adv(rd_idx, cap);
          i_next                = i + CNT_W'(1);
          if (i + CNT_W'(1) == n) begin
            state_next = drop ? S_DROP : S_IDLE;
          end else begin
            state_next = S_POP_RD;
          end
        end
      end
      S_DROP: begin
        rd_idx_next = adv(rd_idx, cap);
        state_next  = S_IDLE;
      end
      S_RESULT: begin
        if (out_free) begin
          o_valid_next          = 1'b1;
          o_res_next.data_byte  = '0;
          o_res_next.data_valid = 1'b0;
          o_res_next.last       = 1'b1;
          o_res_next.status     = st;
          o_res_next.before_cnt = '0;
          o_res_next.fill       = fin;
          state_next            = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (cfg_clear) begin
      rd_idx_next = '0;
      wr_idx_next = '0;
      held_next   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_idx  <= '0;
      wr_idx  <= '0;
      held    <= '0;
      o_valid <= 1'b0;
    end else begin
      state   <= state_next;
      rd_idx  <= rd_idx_next;
      wr_idx  <= wr_idx_next;
      held    <= held_next;
      o_valid <= o_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    cur   <= cur_next;
    ptr   <= ptr_next;
    fin   <= fin_next;
    i     <= i_next;
    n     <= n_next;
    bef   <= bef_next;
    lim   <= lim_next;
    st    <= st_next;
    drop  <= drop_next;
    o_res <= o_res_next;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wbyte;
    if (re) rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/byte_ring_fifo_with_block_ops_core.sv @@
// Channel  | Direction | Handshake                 | Contents
// s_*      | in        | s_tvalid / s_tready       | tuser: kind; tdata: write_data, count,
//          |           |                           |   delimiter
// m_*      | out       | m_tvalid / m_tready       | tuser: data_valid; tlast: last; tdata:
//          |           |                           |   data_byte, status, before, fill_level
// APB      | in        | psel, penable, pwrite     | register 0 at address 0: capacity
//
// An item that gives one result without touching the store goes from the idle state through the
// result state to the output register; push block writes its bytes one after another in the
// push state. Each byte that is popped is first read from the byte store and then loaded into
// the output register, and each byte scanned for a delimiter is likewise read and then compared.
// Reset clears the indices and the fill count at once; the store itself needs no clearing.
// A stalled output only holds the back end; the front register and a two-deep command queue
// keep taking items until they fill.
module byte_ring_fifo_with_block_ops_core import brf_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // write_data[63:0], count[70:64], delimiter[78:71], zero
  input  logic [2:0]  s_tuser,   // kind
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // data_byte[7:0], status[9:8], before[16:10], fill[25:17]
  output logic        m_tuser,   // data_valid
  output logic        m_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [FILL_W-1:0] capacity;
  logic [FILL_W-1:0] cap_eff;
  logic              cfg_clear;
  logic              f_valid, f_ready, q_valid, q_ready;
  cmd_t              f_cmd, q_cmd;
  res_t              res;

  // Capacity register: a write also empties the queue.
  assign pready    = 1'b1;
  assign cfg_clear = psel && penable && pwrite && pready && (paddr == 3'd0);
  assign prdata    = (paddr == 3'd0) ? {{(32-FILL_W){1'b0}}, capacity} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= FILL_W'(DEPTH);
    end else if (cfg_clear) begin
      capacity <= pwdata[FILL_W-1:0];
    end
  end

  // Zero counts as one cell and anything above the store size as the whole store.
  assign cap_eff = (capacity == '0) ? FILL_W'(1) :
                   (capacity > FILL_W'(DEPTH)) ? FILL_W'(DEPTH) : capacity;

  brf_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_kind   (s_tuser),
    .in_wdata  (s_tdata[63:0]),
    .in_count  (s_tdata[70:64]),
    .in_delim  (s_tdata[78:71]),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  brf_cmd_q u_q (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_cmd    (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_cmd   (q_cmd)
  );

  brf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_clear (cfg_clear),
    .cap       (cap_eff),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .res_valid (m_tvalid),
    .res_ready (m_tready),
    .res       (res)
  );

  assign m_tdata = {6'b0, res.fill, res.before_cnt, res.status, res.data_byte};
  assign m_tuser = res.data_valid;
  assign m_tlast = res.last;

endmodule

@@ hw/rtl/brf_checker.sv @@
module brf_checker import brf_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  // A stalled output beat keeps its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  // A beat without data carries a zero byte.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("data byte set on a beat without data");

  // Fill level never exceeds the store size.
  a_fill: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[25:17] <= 9'(DEPTH))
    else $error("fill level out of range");

  // An error status is always a single beat without data.
  a_err: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9:8] != ST_OK |-> m_tlast && !m_tuser && m_tdata[16:10] == 7'd0)
    else $error("error status on a data beat");

endmodule

bind byte_ring_fifo_with_block_ops_core brf_checker u_brf_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
